[hw/rtl/llts_pkg.sv]
// Shared types and constants for the tails-table LIS length block.
`default_nettype none
package llts_pkg;

  // Fixed width of the reported length field
  localparam int unsigned LEN_W = 11;
  // Width of the length field padded to whole bytes on the result bus
  localparam int unsigned OUT_DATA_W = 16;

  // One result item as handed from the sequencer to the output stage
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             overflow;
  } llts_res_t;

endpackage : llts_pkg
`default_nettype wire

[hw/rtl/lis_length_tails_search.sv]
// On an empty table the value is written as the only tail; otherwise the last tail is read first,
//   then the value is appended, dropped as overflow on a full table, written over the first tail
//   on a one-entry table, or placed by a binary search. Items are taken one at a time;
//   the search probes the tails memory once a cycle through its registered read port.
// The output register lets the next item in while a result waits to be taken.
// Reset (synchronous, active low) empties the table and the output register;
// tail memory contents are left as they are and never read before written.
`default_nettype none
module lis_length_tails_search #(
  parameter int unsigned MAX_LEN     = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input stream
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] in_tdata,  // value
  input  wire logic                                  in_tuser,  // start_req
  // result stream
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [llts_pkg::OUT_DATA_W-1:0]            out_tdata, // length, zero pad
  output logic                                       out_tuser  // overflow
);
  import llts_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);

  logic                   res_valid;
  logic                   res_ready;
  llts_res_t              res;
  logic                   ram_wr_en;
  logic [AW-1:0]          ram_wr_addr;
  logic [VALUE_WIDTH-1:0] ram_wr_data;
  logic                   ram_rd_en;
  logic [AW-1:0]          ram_rd_addr;
  logic [VALUE_WIDTH-1:0] ram_rd_data;

  logic                   out_valid_r;
  llts_res_t              out_res_r;

  llts_ctrl #(
    .MAX_LEN     (MAX_LEN),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .value       (in_tdata[VALUE_WIDTH-1:0]),
    .start_req   (in_tuser),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  llts_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_LEN)
  ) u_tails (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Take a result when the output register is empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r.length);
  assign out_tuser  = out_res_r.overflow;

endmodule : lis_length_tails_search
`default_nettype wire

[hw/rtl/llts_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none
module llts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : llts_ram
`default_nettype wire

[hw/rtl/llts_ctrl.sv]
// Sequencer: checks the last tail, appends or binary-searches the tails, one probe a cycle.
`default_nettype none
module llts_ctrl #(
  parameter int unsigned MAX_LEN     = 1024,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // item in
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [VALUE_WIDTH-1:0]     value,
  input  wire logic                       start_req,
  // result out
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output llts_pkg::llts_res_t             res,
  // tails memory
  output logic                            ram_wr_en,
  output logic [$clog2(MAX_LEN)-1:0]      ram_wr_addr,
  output logic [VALUE_WIDTH-1:0]          ram_wr_data,
  output logic                            ram_rd_en,
  output logic [$clog2(MAX_LEN)-1:0]      ram_rd_addr,
  input  wire logic [VALUE_WIDTH-1:0]     ram_rd_data
);
  import llts_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAST,
    ST_SEARCH,
    ST_FIN
  } state_t;

  state_t               state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] key_r, key_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]        lo_r, lo_nxt;
  logic [AW-1:0]        hi_r, hi_nxt;
  logic [AW-1:0]        mid_r, mid_nxt;
  logic                 ovf_r, ovf_nxt;

  logic [VALUE_WIDTH-1:0] key_in;
  logic [CW-1:0]        cnt_eff;
  logic [AW-1:0]        hi_first;
  logic [AW-1:0]        lo_step;
  logic [AW-1:0]        hi_step;
  logic [AW:0]          sum_first;
  logic [AW:0]          sum_step;

  // Flip the sign bit so that unsigned order matches signed order
  assign key_in  = {~value[VALUE_WIDTH-1], value[VALUE_WIDTH-2:0]};
  assign cnt_eff = start_req ? '0 : cnt_r;

  // Search bounds for the first probe and for each later probe
  assign hi_first  = AW'(cnt_r - CW'(1));
  assign sum_first = {1'b0, hi_first};
  assign lo_step   = (ram_rd_data < key_r) ? AW'({1'b0, mid_r} + {{AW{1'b0}}, 1'b1}) : lo_r;
  assign hi_step   = (ram_rd_data < key_r) ? hi_r : mid_r;
  assign sum_step  = {1'b0, lo_step} + {1'b0, hi_step};

  assign in_ready     = (state_r == ST_IDLE);
  assign res_valid    = (state_r == ST_FIN);
  assign res.length   = LEN_W'(cnt_r);
  assign res.overflow = ovf_r;

  // Next state, memory accesses and table updates
  always_comb begin
    state_nxt   = state_r;
    key_nxt     = key_r;
    cnt_nxt     = cnt_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    ovf_nxt     = ovf_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = key_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt = key_in;
          ovf_nxt = 1'b0;
          if (cnt_eff == '0) begin
            // empty table: the value becomes the only tail
            ram_wr_en   = 1'b1;
            ram_wr_data = key_in;
            cnt_nxt     = CW'(1);
            state_nxt   = ST_FIN;
          end else begin
            // fetch the last tail
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(cnt_eff - CW'(1));
            cnt_nxt     = cnt_eff;
            state_nxt   = ST_LAST;
          end
        end
      end
      ST_LAST: begin
        if (key_r > ram_rd_data) begin
          // append, or flag overflow on a full table
          if (cnt_r < CW'(MAX_LEN)) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = AW'(cnt_r);
            cnt_nxt     = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          state_nxt = ST_FIN;
        end else if (hi_first == '0) begin
          // single candidate: replace the first tail
          ram_wr_en = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          // answer lies in [0, count-1]; issue the first probe
          lo_nxt      = '0;
          hi_nxt      = hi_first;
          mid_nxt     = sum_first[AW:1];
          ram_rd_en   = 1'b1;
          ram_rd_addr = sum_first[AW:1];
          state_nxt   = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
        if (lo_step == hi_step) begin
          // first tail not below the key found: overwrite it
          ram_wr_en   = 1'b1;
          ram_wr_addr = lo_step;
          state_nxt   = ST_FIN;
        end else begin
          mid_nxt     = sum_step[AW:1];
          ram_rd_en   = 1'b1;
          ram_rd_addr = sum_step[AW:1];
        end
      end
      ST_FIN: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
    key_r <= key_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
  end

endmodule : llts_ctrl
`default_nettype wire

[bench/lis_length_tails_search_tb.sv]
// Self-checking testbench for the streaming LIS length block (tails table search).
`default_nettype none
module lis_length_tails_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import llts_pkg::*;

  localparam int unsigned DEPTH      = 1024;
  localparam int unsigned VW         = 32;
  localparam int unsigned ITEM_TOTAL = 1550;
  localparam int unsigned DIR_ROWS   = 22;
  localparam logic [VW-1:0] V_MIN    = 32'h8000_0000;
  localparam logic [VW-1:0] V_MAX    = 32'h7FFF_FFFF;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [VW-1:0]         in_tdata;   // value
  logic                  in_tuser;   // start_req
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // length, zero pad
  logic                  out_tuser;  // overflow

  lis_length_tails_search #(
    .MAX_LEN     (DEPTH),
    .VALUE_WIDTH (VW)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Directed row: value, start flag, whether the result is typed in, typed length/overflow
  typedef struct packed {
    logic [VW-1:0]    value;
    logic             start;
    logic             typed;
    logic [LEN_W-1:0] len;
    logic             ovf;
  } lis_row_t;

  lis_row_t dir_rows [DIR_ROWS] = '{
    '{32'd0,         1'b0, 1'b1, 11'd1, 1'b0},  // first item after reset
    '{V_MIN,         1'b0, 1'b1, 11'd1, 1'b0},  // most negative replaces it
    '{V_MAX,         1'b0, 1'b1, 11'd2, 1'b0},  // most positive appends
    '{V_MAX,         1'b0, 1'b1, 11'd2, 1'b0},  // repeat of last tail
    '{V_MIN,         1'b0, 1'b1, 11'd2, 1'b0},  // repeat of first tail
    '{32'd5,         1'b0, 1'b1, 11'd2, 1'b0},
    '{32'd6,         1'b0, 1'b1, 11'd3, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 11'd3, 1'b0},
    '{32'd100,       1'b1, 1'b1, 11'd1, 1'b0},  // new sequence
    '{V_MIN,         1'b1, 1'b1, 11'd1, 1'b0},
    '{V_MIN + 32'd1, 1'b0, 1'b1, 11'd2, 1'b0},
    '{V_MAX,         1'b1, 1'b1, 11'd1, 1'b0},
    '{V_MAX,         1'b0, 1'b1, 11'd1, 1'b0},
    '{32'd0,         1'b0, 1'b1, 11'd1, 1'b0},
    '{32'd3,         1'b1, 1'b0, 11'd0, 1'b0},
    '{32'd1,         1'b0, 1'b0, 11'd0, 1'b0},
    '{32'd4,         1'b0, 1'b0, 11'd0, 1'b0},
    '{32'd1,         1'b0, 1'b0, 11'd0, 1'b0},
    '{32'd5,         1'b0, 1'b0, 11'd0, 1'b0},
    '{32'd9,         1'b0, 1'b0, 11'd0, 1'b0},
    '{32'hFFFF_FFFE, 1'b0, 1'b0, 11'd0, 1'b0},
    '{32'd6,         1'b0, 1'b0, 11'd0, 1'b0}
  };

  // Predictor state: sorted tails and their count
  logic signed [VW-1:0] tails_model [DEPTH];
  int unsigned          tail_total;

  llts_res_t   lis_expect_q [$];
  int unsigned fail_count;
  int unsigned items_sent;
  bit          idle_on;
  int unsigned stall_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit on run time
  initial begin
    #20_000_000;
    $display("lis_length_tails_search verification failed");
    $finish;
  end

  // Pick an idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // Advance the tails table by one value and return the expected result
  function automatic llts_res_t predict_lis(input logic signed [VW-1:0] v, input logic s);
    llts_res_t   res;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    res.overflow = 1'b0;
    if (s) tail_total = 0;
    if (tail_total == 0 || v > tails_model[tail_total-1]) begin
      if (tail_total < DEPTH) begin
        tails_model[tail_total] = v;
        tail_total++;
      end else begin
        res.overflow = 1'b1;
      end
    end else begin
      lo = 0;
      hi = tail_total;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (tails_model[mid] < v) lo = mid + 1;
        else hi = mid;
      end
      tails_model[lo] = v;
    end
    res.length = tail_total[LEN_W-1:0];
    return res;
  endfunction

  // Offer one item, hold it until taken, then log its expected result
  task automatic send_lis_item(input logic [VW-1:0] v, input logic s,
                               input logic use_typed, input llts_res_t typed_res);
    int unsigned gap;
    llts_res_t   res;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tuser  <= s;
    do @(posedge clk); while (!in_tready);
    res = predict_lis(v, s);
    lis_expect_q.insert(lis_expect_q.size(), use_typed ? typed_res : res);
    items_sent++;
  endtask

  // Result side: check every item taken, then choose the next ready level
  initial begin
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (lis_expect_q.size() == 0) begin
          $error("result with nothing expected: length %0d overflow %0b",
                 out_tdata[LEN_W-1:0], out_tuser);
          fail_count++;
        end else begin
          llts_res_t want;
          want = lis_expect_q.pop_front();
          if (out_tdata[LEN_W-1:0] !== want.length) begin
            $error("length: expected %0d, actual %0d", want.length, out_tdata[LEN_W-1:0]);
            fail_count++;
          end
          if (out_tdata[OUT_DATA_W-1:LEN_W] !== '0) begin
            $error("pad: expected 0, actual %0h", out_tdata[OUT_DATA_W-1:LEN_W]);
            fail_count++;
          end
          if (out_tuser !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, out_tuser);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  // Stimulus
  initial begin
    logic signed [VW-1:0] run_val;
    logic [VW-1:0]        v;
    logic                 s;
    int unsigned          seq_len;
    int unsigned          mode;
    int unsigned          k;
    llts_res_t            none;
    none       = '0;
    fail_count = 0;
    items_sent = 0;
    tail_total = 0;
    idle_on    = 1'b1;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++)
      send_lis_item(dir_rows[i].value, dir_rows[i].start, dir_rows[i].typed,
                    '{length: dir_rows[i].len, overflow: dir_rows[i].ovf});

    // Fill the table to the top with a rising run, odd replacements mixed in
    run_val = $signed(V_MIN) + $signed($urandom_range(0, 32'h3FFF_FFFF));
    send_lis_item(run_val, 1'b1, 1'b0, none);
    k = 0;
    while (tail_total < DEPTH) begin
      if (k % 256 == 0) idle_on = ~idle_on;
      k++;
      if ($urandom_range(0, 19) == 0 && run_val > $signed(V_MIN) + 32'sd2_000_000) begin
        send_lis_item(run_val - $signed($urandom_range(0, 1_000_000)), 1'b0, 1'b0, none);
      end else begin
        run_val = run_val + $signed($urandom_range(1, 32'h001F_FFFF));
        send_lis_item(run_val, 1'b0, 1'b0, none);
      end
    end
    idle_on = 1'b1;
    // Appends on a full table are dropped
    for (int i = 0; i < 12; i++) begin
      run_val = run_val + $signed($urandom_range(1, 1000));
      send_lis_item(run_val, 1'b0, 1'b0, none);
    end
    send_lis_item(V_MAX, 1'b0, 1'b0, none);
    // Random values while full: replacements, or dropped appends
    for (int i = 0; i < 12; i++) send_lis_item($urandom, 1'b0, 1'b0, none);

    // Short sequences of assorted shapes
    while (items_sent < ITEM_TOTAL) begin
      seq_len = $urandom_range(1, 40);
      mode    = $urandom_range(0, 3);
      idle_on = ($urandom_range(0, 3) != 0);
      run_val = $signed(V_MIN) + $signed($urandom_range(0, 32'h00FF_FFFF));
      for (int i = 0; i < seq_len; i++) begin
        case (mode)
          0: begin
            v = $urandom;
          end
          1: begin
            v = $signed($urandom_range(0, 16)) - 32'sd8;
          end
          2: begin
            case ($urandom_range(0, 5))
              0: v = V_MIN;
              1: v = V_MIN + 32'd1;
              2: v = V_MAX - 32'd1;
              3: v = V_MAX;
              4: v = '0;
              default: v = '1;
            endcase
          end
          default: begin
            run_val = run_val + $signed($urandom_range(0, 32'h00FF_FFFF));
            v = ($urandom_range(0, 7) == 0) ? $urandom : run_val;
          end
        endcase
        if (i == 0) s = ($urandom_range(0, 9) != 0);
        else s = ($urandom_range(0, 24) == 0);
        send_lis_item(v, s, 1'b0, none);
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then allow the search latency to settle
    while (lis_expect_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("lis_length_tails_search verification clean");
    end else begin
      $display("lis_length_tails_search verification failed");
    end
    $finish;
  end

endmodule : lis_length_tails_search_tb
`default_nettype wire

[lis_length_tails_search.f]
hw/rtl/llts_pkg.sv
hw/rtl/llts_ram.sv
hw/rtl/llts_ctrl.sv
hw/rtl/lis_length_tails_search.sv
bench/lis_length_tails_search_tb.sv
